// ===== rtl/brt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package brt_pkg;
  localparam int unsigned MaxRowsDef   = 256;
  localparam int unsigned MaxColsDef   = 256;
  localparam int unsigned ValueBitsDef = 24;

  // Configuration register indexes and widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 23;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIterations = 3'd1;
  localparam logic [CfgIdxW-1:0] RegImageRows  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegImageCols  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutletRow  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOutletCol  = 3'd5;

  localparam int unsigned ThreshW = 23;
  localparam int unsigned IterW   = 8;
  localparam int unsigned DimW    = 9;
  localparam int unsigned OutletW = 8;

  // Opcodes
  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  // Pass directions
  localparam logic [1:0] DirNorth = 2'd0;
  localparam logic [1:0] DirWest  = 2'd1;
  localparam logic [1:0] DirEast  = 2'd2;
  localparam logic [1:0] DirSouth = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/brt_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface brt_in_if #(
  parameter int unsigned VALUE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [VALUE_BITS-1:0] accum_value;

  modport source (output valid, output opcode, output accum_value, input ready);
  modport sink   (input valid, input opcode, input accum_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/brt_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface brt_out_if;
  logic valid;
  logic ready;
  logic thin_bit;
  logic last_pixel;

  modport source (output valid, output thin_bit, output last_pixel, input ready);
  modport sink   (input valid, input thin_bit, input last_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/brt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module brt_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/binary_raster_thinning.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load: one item per cycle while idle and no read result waits. Read: the RAM
// read data is registered, then held in the output register until taken.
// The last load of an image starts the thinning: hole filling over all
// rows*cols pixels, then per round border clearing and the north, west, east
// and south passes; each pixel reads its 3x3 window over the single read port
// of the current RAM bank, one neighbour a cycle. No items are taken then.
// Reset (async, active low) restores control state and config, not the RAMs.
module binary_raster_thinning
  import brt_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = MaxRowsDef,
  parameter int unsigned MAX_COLS   = MaxColsDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  brt_in_if.sink                   in_i,
  brt_out_if.source                out_o
);
  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned TW    = AW + 1;
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned DW    = (RW > CW) ? RW : CW;
  localparam int unsigned XW    = ((DW > DimW) ? DW : DimW) + 1;
  localparam int unsigned VW    = ((VALUE_BITS > ThreshW) ? VALUE_BITS : ThreshW) + 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StFill  = 3'd2;
  localparam logic [2:0] StClear = 3'd3;
  localparam logic [2:0] StPass  = 3'd4;

  localparam logic [3:0] StepLast = 4'd10;

  // Configuration registers
  logic [ThreshW-1:0] thresh_q;
  logic [IterW-1:0]   iter_q;
  logic [DimW-1:0]    rows_cfg_q, cols_cfg_q;
  logic [OutletW-1:0] orow_q, ocol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= '0;
      iter_q     <= IterW'(1);
      rows_cfg_q <= DimW'(256);
      cols_cfg_q <= DimW'(256);
      orow_q     <= '0;
      ocol_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegThreshold:  thresh_q   <= cfg_data_i[ThreshW-1:0];
        RegIterations: iter_q     <= cfg_data_i[IterW-1:0];
        RegImageRows:  rows_cfg_q <= cfg_data_i[DimW-1:0];
        RegImageCols:  cols_cfg_q <= cfg_data_i[DimW-1:0];
        RegOutletRow:  orow_q     <= cfg_data_i[OutletW-1:0];
        RegOutletCol:  ocol_q     <= cfg_data_i[OutletW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped image size
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic [TW-1:0] total;
  always_comb begin
    if (XW'(rows_cfg_q) < XW'(3))             rows = RW'(3);
    else if (XW'(rows_cfg_q) > XW'(MAX_ROWS)) rows = RW'(MAX_ROWS);
    else                                      rows = RW'(rows_cfg_q);
    if (XW'(cols_cfg_q) < XW'(3))             cols = CW'(3);
    else if (XW'(cols_cfg_q) > XW'(MAX_COLS)) cols = CW'(MAX_COLS);
    else                                      cols = CW'(cols_cfg_q);
    total = TW'(rows) * TW'(cols);
  end

  // State
  logic [2:0]    state_q, state_d;
  logic          bank_q, bank_d;
  logic [AW-1:0] k_q, k_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [3:0]    step_q, step_d;
  logic [1:0]    dir_q, dir_d;
  logic [IterW-1:0] round_q, round_d;
  logic [8:0]    nb_q, nb_d;
  logic [AW-1:0] lpos_q, lpos_d, rpos_q, rpos_d;
  logic          ovalid_q, ovalid_d, obit_q, obit_d, olast_q, olast_d;
  logic          rlast_q, rlast_d;

  // RAM ports
  logic          we, wbank, wdata;
  logic [AW-1:0] waddr, raddr;
  logic          rdata0, rdata1, rdata;
  assign rdata = bank_q ? rdata1 : rdata0;

  brt_ram #(.WIDTH(1), .DEPTH(Depth)) u_ram0 (
    .clk_i, .we_i(we && !wbank), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata0)
  );
  brt_ram #(.WIDTH(1), .DEPTH(Depth)) u_ram1 (
    .clk_i, .we_i(we && wbank), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata1)
  );

  // Window neighbour address: 0 self, 1 n, 2 nw, 3 w, 4 sw, 5 s, 6 se, 7 e, 8 ne
  logic [AW-1:0] cext, nb_addr;
  assign cext = AW'(cols);
  always_comb begin
    case (step_q)
      4'd1:    nb_addr = k_q - cext;
      4'd2:    nb_addr = k_q - cext - AW'(1);
      4'd3:    nb_addr = k_q - AW'(1);
      4'd4:    nb_addr = k_q + cext - AW'(1);
      4'd5:    nb_addr = k_q + cext;
      4'd6:    nb_addr = k_q + cext + AW'(1);
      4'd7:    nb_addr = k_q + AW'(1);
      4'd8:    nb_addr = k_q - cext + AW'(1);
      default: nb_addr = k_q;
    endcase
  end

  // Pixel decision from the registered window
  logic px, n, nw, w, sw, s, se, e, ne, bn, bs, be, bw;
  logic interior, outlet, fill_set, pass_bit, sum_nz;
  logic [3:0] cnt;
  always_comb begin
    {ne, e, se, s, sw, w, nw, n, px} = nb_q;
    bn = !n; bs = !s; be = !e; bw = !w;
    cnt = 4'(n) + 4'(nw) + 4'(w) + 4'(sw) + 4'(s) + 4'(se) + 4'(e) + 4'(ne);
    interior = (row_q != '0) && (row_q != rows - RW'(1)) &&
               (col_q != '0) && (col_q != cols - CW'(1));
    outlet = (XW'(row_q) == XW'(orow_q)) && (XW'(col_q) == XW'(ocol_q));
    fill_set = interior && !px && n && w && s && e;
    case (dir_q)
      DirNorth: sum_nz = (w & bs & e) | (bw & nw & bn) | (bn & ne & be) |
                         (be & se & bs) | (bs & sw & bw);
      DirWest:  sum_nz = (n & be & s) | (bw & sw & bs) | (bs & se & be) |
                         (be & ne & bn) | (bn & nw & bw);
      DirEast:  sum_nz = (n & bw & s) | (bn & ne & be) | (bs & se & be) |
                         (bw & sw & bs) | (bw & nw & bn);
      default:  sum_nz = (w & bn & e) | (bw & sw & bs) | (bs & se & be) |
                         (be & ne & bn) | (bn & nw & bw);
    endcase
    pass_bit = px;
    if (px && interior && !outlet) begin
      if (cnt == 4'd0) begin
        pass_bit = 1'b0;
      end else begin
        case (dir_q)
          DirNorth: pass_bit = n | sum_nz;
          DirWest:  pass_bit = w | sum_nz;
          DirEast:  pass_bit = e | sum_nz;
          default:  pass_bit = s | sum_nz;
        endcase
        if (dir_q != DirSouth && cnt == 4'd1) pass_bit = 1'b1;
      end
    end
  end

  // Load threshold and positions
  logic          above;
  logic [AW-1:0] lpos_use, rpos_use;
  logic          pix_end;
  assign above = $signed(VW'($signed(in_i.accum_value))) >= $signed(VW'(thresh_q));
  assign lpos_use = (TW'(lpos_q) >= total) ? '0 : lpos_q;
  assign rpos_use = (TW'(rpos_q) >= total) ? '0 : rpos_q;
  assign pix_end  = (TW'(k_q) == total - TW'(1));

  assign in_i.ready     = (state_q == StIdle) && !ovalid_q;
  assign out_o.valid    = ovalid_q;
  assign out_o.thin_bit = obit_q;
  assign out_o.last_pixel = olast_q;

  // Sequencer
  always_comb begin
    state_d = state_q; bank_d = bank_q; k_d = k_q; row_d = row_q; col_d = col_q;
    step_d = step_q; dir_d = dir_q; round_d = round_q; nb_d = nb_q;
    lpos_d = lpos_q; rpos_d = rpos_q; rlast_d = rlast_q;
    ovalid_d = ovalid_q; obit_d = obit_q; olast_d = olast_q;
    we = 1'b0; wbank = bank_q; wdata = 1'b0; waddr = k_q; raddr = nb_addr;

    if (ovalid_q && out_o.ready) ovalid_d = 1'b0;

    case (state_q)
      StIdle: begin
        raddr = rpos_use;
        if (in_i.valid && in_i.ready) begin
          if (in_i.opcode == OpLoad) begin
            we = 1'b1; waddr = lpos_use; wdata = above;
            if (TW'(lpos_use) + TW'(1) == total) begin
              lpos_d = '0; rpos_d = '0;
              k_d = '0; row_d = '0; col_d = '0; step_d = '0;
              state_d = StFill;
            end else begin
              lpos_d = lpos_use + AW'(1);
            end
          end else begin
            rlast_d = (TW'(rpos_use) == total - TW'(1));
            rpos_d = rlast_d ? '0 : rpos_use + AW'(1);
            state_d = StRead;
          end
        end
      end
      StRead: begin
        ovalid_d = 1'b1; obit_d = rdata; olast_d = rlast_q;
        state_d = StIdle;
      end
      StClear: begin
        we = !interior; wdata = 1'b0;
        if (pix_end) begin
          k_d = '0; row_d = '0; col_d = '0; step_d = '0; dir_d = DirNorth;
          state_d = StPass;
        end
      end
      default: begin
        // window gather for fill and pass
        if (step_q != 4'd0 && step_q != StepLast) nb_d[step_q - 4'd1] = rdata;
        if (step_q == StepLast) begin
          we = 1'b1;
          if (state_q == StFill) begin
            wdata = px | fill_set;
          end else begin
            wdata = pass_bit; wbank = !bank_q;
          end
          step_d = '0;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
    endcase

    // pixel scan advance
    if ((state_q == StClear) || ((state_q == StFill || state_q == StPass) &&
        step_q == StepLast)) begin
      if (col_q == cols - CW'(1)) begin
        col_d = '0; row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
      k_d = k_q + AW'(1);
      if (pix_end) begin
        k_d = '0; row_d = '0; col_d = '0;
        if (state_q == StFill) begin
          round_d = '0;
          state_d = (iter_q == '0) ? StIdle : StClear;
        end else if (state_q == StPass) begin
          bank_d = !bank_q;
          dir_d = dir_q + 2'd1;
          if (dir_q == DirSouth) begin
            if (round_q + IterW'(1) == iter_q) begin
              round_d = '0; state_d = StIdle;
            end else begin
              round_d = round_q + IterW'(1); state_d = StClear;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; bank_q <= 1'b0; k_q <= '0; row_q <= '0; col_q <= '0;
      step_q <= '0; dir_q <= DirNorth; round_q <= '0; lpos_q <= '0; rpos_q <= '0;
      ovalid_q <= 1'b0; rlast_q <= 1'b0;
    end else begin
      state_q <= state_d; bank_q <= bank_d; k_q <= k_d; row_q <= row_d;
      col_q <= col_d; step_q <= step_d; dir_q <= dir_d; round_q <= round_d;
      lpos_q <= lpos_d; rpos_q <= rpos_d; ovalid_q <= ovalid_d; rlast_q <= rlast_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    nb_q <= nb_d; obit_q <= obit_d; olast_q <= olast_d;
  end
endmodule
`default_nettype wire
